/* hdl/jac3_pkg.sv */
// Shared types and constants for the 3x3 Jacobi solver
`default_nettype none
package jac3_pkg;
    localparam int ITERATIONS_DEF  = 20;
    localparam int FRAC_BITS_DEF   = 24;
    localparam int VALUE_WIDTH_DEF = 48;
    localparam int COEF_WIDTH_DEF  = 16;
    localparam int TOL_WIDTH       = 25;
    localparam int ITER_WIDTH      = 7;
    localparam int WIDE_WIDTH      = 64;
    localparam int NUM_LANES       = 3;
    localparam logic [TOL_WIDTH-1:0] TOL_X_RESET  = 25'd16777;
    localparam logic [TOL_WIDTH-1:0] TOL_YZ_RESET = 25'd1678;
    localparam logic [0:0] REG_TOL_X  = 1'b0;
    localparam logic [0:0] REG_TOL_YZ = 1'b1;
    localparam int CFG_IDX_WIDTH = 2;

    typedef logic signed [WIDE_WIDTH-1:0] t_wide;

    typedef struct packed {
        logic start;
        logic done;
    } t_lane_ctl;
endpackage
`default_nettype wire

/* hdl/jac3_lane.sv */
// One solver lane: multiply-accumulate of the numerator, then restoring division
`default_nettype none
module jac3_lane #(
    parameter int FRAC_BITS   = jac3_pkg::FRAC_BITS_DEF,
    parameter int VALUE_WIDTH = jac3_pkg::VALUE_WIDTH_DEF,
    parameter int COEF_WIDTH  = jac3_pkg::COEF_WIDTH_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_start,
    input  wire logic signed [COEF_WIDTH-1:0]   i_diag,
    input  wire logic signed [COEF_WIDTH-1:0]   i_c1,
    input  wire logic signed [VALUE_WIDTH-1:0]  i_v1,
    input  wire logic signed [COEF_WIDTH-1:0]   i_c2,
    input  wire logic signed [VALUE_WIDTH-1:0]  i_v2,
    input  wire logic signed [COEF_WIDTH-1:0]   i_rhs,
    output logic                                o_done,
    output logic signed [VALUE_WIDTH-1:0]       o_quot
);
    import jac3_pkg::*;

    localparam int W = WIDE_WIDTH;
    localparam int PW = COEF_WIDTH + VALUE_WIDTH;
    localparam int CW = $clog2(W + 1);
    localparam t_wide HI = {1'b0, {(W-1){1'b1}}};
    localparam t_wide LO = -HI;
    localparam logic signed [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_SUB1, S_SUB2, S_DIV, S_FIN} t_state;

    t_state r_state;
    logic signed [PW-1:0] r_p1, r_p2;
    t_wide r_num;
    logic [W-1:0] r_mag, r_rem;
    logic [COEF_WIDTH-1:0] r_dmag;
    logic r_neg, r_nneg, r_dzero;
    logic [CW-1:0] r_cnt;
    logic r_done;
    logic signed [VALUE_WIDTH-1:0] r_quot;

    t_wide rhs_sc, p1w, p2w, sub1, sub2;
    logic [W:0] trial;
    logic [W-1:0] qmag;

    function automatic t_wide sat_sub(input t_wide a, input t_wide b);
        logic signed [W:0] s;
        s = {a[W-1], a} - {b[W-1], b};
        if (s > $signed({1'b0, HI})) return HI;
        if (s < $signed({LO[W-1], LO})) return LO;
        return s[W-1:0];
    endfunction

    function automatic t_wide sat_prod(input logic signed [PW-1:0] p);
        if (p > $signed({{(PW-W){1'b0}}, HI})) return HI;
        if (p < $signed({{(PW-W){1'b1}}, LO})) return LO;
        return t_wide'(p);
    endfunction

    assign rhs_sc = t_wide'(i_rhs) <<< FRAC_BITS;
    assign p1w = sat_prod(r_p1);
    assign p2w = sat_prod(r_p2);
    assign sub1 = sat_sub(r_num, p1w);
    assign sub2 = sat_sub(r_num, p2w);
    assign trial = {r_rem, r_mag[W-1]} - {{(W+1-COEF_WIDTH){1'b0}}, r_dmag};
    assign qmag = r_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_p1   <= PW'(i_c1) * PW'(i_v1);
                        r_p2   <= PW'(i_c2) * PW'(i_v2);
                        r_num  <= rhs_sc;
                        r_dzero <= (i_diag == '0);
                        r_dmag <= i_diag[COEF_WIDTH-1] ? COEF_WIDTH'(-i_diag) : i_diag;
                        r_neg  <= i_diag[COEF_WIDTH-1];
                        r_state <= S_MUL;
                    end
                end
                S_MUL: r_state <= S_SUB1;
                S_SUB1: begin
                    r_num <= sub1;
                    r_state <= S_SUB2;
                end
                S_SUB2: begin
                    r_num <= sub2;
                    r_nneg <= sub2[W-1];
                    r_neg <= r_neg ^ sub2[W-1];
                    r_mag <= sub2[W-1] ? W'(-sub2) : sub2;
                    r_rem <= '0;
                    r_cnt <= CW'(W);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (!trial[W]) begin
                        r_rem <= trial[W-1:0];
                        r_mag <= {r_mag[W-2:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[W-2:0], r_mag[W-1]};
                        r_mag <= {r_mag[W-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) r_state <= S_FIN;
                end
                S_FIN: begin
                    if (r_dzero) begin
                        if (r_num == '0) r_quot <= '0;
                        else r_quot <= r_nneg ? VMIN : VMAX;
                    end else if (!r_neg) begin
                        r_quot <= (qmag > W'(VMAX)) ? VMAX : VALUE_WIDTH'(qmag);
                    end else begin
                        r_quot <= (qmag > W'(VMAX) + W'(1)) ? VMIN
                                  : VALUE_WIDTH'(-qmag);
                    end
                    r_done <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

`ifndef ASSERT_OFF
    a_done_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state) == S_FIN) else $error("lane done without finish");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_cnt != '0) else $error("divide counter underflow");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_state == S_IDLE) else $error("lane busy at done");
`endif
endmodule
`default_nettype wire

/* hdl/jac3_merge.sv */
// Merging stage: changes, convergence check and result formatting
`default_nettype none
module jac3_merge #(
    parameter int ITERATIONS  = jac3_pkg::ITERATIONS_DEF,
    parameter int VALUE_WIDTH = jac3_pkg::VALUE_WIDTH_DEF
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     i_clear,
    input  wire                                     i_valid,
    input  wire logic [jac3_pkg::ITER_WIDTH-1:0]    i_iter,
    input  wire logic signed [VALUE_WIDTH-1:0]      i_old_x, i_old_y, i_old_z,
    input  wire logic signed [VALUE_WIDTH-1:0]      i_new_x, i_new_y, i_new_z,
    input  wire logic [jac3_pkg::TOL_WIDTH-1:0]     i_tol_x,
    input  wire logic [jac3_pkg::TOL_WIDTH-1:0]     i_tol_yz,
    output logic                                    o_valid,
    output logic [jac3_pkg::ITER_WIDTH-1:0]         o_iteration,
    output logic [VALUE_WIDTH-2:0]                  o_change_x, o_change_y, o_change_z,
    output logic signed [VALUE_WIDTH-1:0]           o_sol_x, o_sol_y, o_sol_z,
    output logic                                    o_found,
    output logic [jac3_pkg::ITER_WIDTH-1:0]         o_found_iteration,
    output logic                                    o_last
);
    import jac3_pkg::*;

    localparam logic [VALUE_WIDTH-1:0] CMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

    function automatic logic [VALUE_WIDTH-2:0] adiff(
        input logic signed [VALUE_WIDTH-1:0] a, input logic signed [VALUE_WIDTH-1:0] b);
        logic signed [VALUE_WIDTH:0] d;
        logic [VALUE_WIDTH:0] m;
        d = {a[VALUE_WIDTH-1], a} - {b[VALUE_WIDTH-1], b};
        m = d[VALUE_WIDTH] ? (VALUE_WIDTH+1)'(-d) : d;
        return (m > {1'b0, CMAX}) ? CMAX[VALUE_WIDTH-2:0] : m[VALUE_WIDTH-2:0];
    endfunction

    logic [VALUE_WIDTH-2:0] cx, cy, cz;
    logic hit, lastk;
    logic r_found, r_valid;
    logic [ITER_WIDTH-1:0] r_fit, r_iter;
    logic signed [VALUE_WIDTH-1:0] r_sx, r_sy, r_sz;
    logic [VALUE_WIDTH-2:0] r_cx, r_cy, r_cz;
    logic r_last;

    assign cx = adiff(i_old_x, i_new_x);
    assign cy = adiff(i_old_y, i_new_y);
    assign cz = adiff(i_old_z, i_new_z);
    assign hit = !r_found && cx <= (VALUE_WIDTH-1)'(i_tol_x)
                 && cy <= (VALUE_WIDTH-1)'(i_tol_yz) && cz <= (VALUE_WIDTH-1)'(i_tol_yz);
    assign lastk = (i_iter == ITER_WIDTH'(ITERATIONS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
            if (i_clear) begin
                r_found <= 1'b0;
                r_fit <= '0;
                r_sx <= '0; r_sy <= '0; r_sz <= '0;
            end else if (i_valid && hit) begin
                r_found <= 1'b1;
                r_fit <= i_iter;
                r_sx <= i_new_x; r_sy <= i_new_y; r_sz <= i_new_z;
            end
        end
        if (i_valid) begin
            r_iter <= i_iter;
            r_cx <= cx; r_cy <= cy; r_cz <= cz;
            r_last <= lastk;
        end
    end

    assign o_valid = r_valid;
    assign o_iteration = r_iter;
    assign o_change_x = r_cx;
    assign o_change_y = r_cy;
    assign o_change_z = r_cz;
    assign o_last = r_valid && r_last;
    assign o_found = o_last && r_found;
    assign o_found_iteration = o_last ? r_fit : '0;
    assign o_sol_x = o_last ? r_sx : '0;
    assign o_sol_y = o_last ? r_sy : '0;
    assign o_sol_z = o_last ? r_sz : '0;

`ifndef ASSERT_OFF
    a_found_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found && !$past(i_clear) && $past(r_found) |-> $stable(r_fit))
        else $error("found iteration changed");
    a_found_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_found |-> o_found_iteration != '0) else $error("found without iteration");
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("results back to back");
`endif
endmodule
`default_nettype wire

/* hdl/jacobi_3x3_solver_top.sv */
// Top level of the 3x3 Jacobi solver: control, three lanes and merge stage
// Channel | signals                          | handshake
// item    | i_start, i_eq*_*                 | taken when i_start && !o_busy
// result  | o_valid, o_iteration .. o_last   | one-cycle strobe, no back-pressure
// config  | i_cfg_we, i_cfg_idx, i_cfg_data  | written on each edge with i_cfg_we, idx 0 or 1
// One sweep runs start, the multiply and both numerator subtractions, 64 divide steps, finish,
// hand-off to the merge stage and the update of x, y and z.
// An item holds o_busy high for ITERATIONS sweeps.
// The last result appears in the same cycle that o_busy falls, when a new item may already be taken.
// The three lanes divide at the same time; the receiver cannot stall the block.
// Reset is synchronous, active low, and restores the tolerance defaults.
`default_nettype none
module jacobi_3x3_solver_top #(
    parameter int ITERATIONS  = jac3_pkg::ITERATIONS_DEF,
    parameter int FRAC_BITS   = jac3_pkg::FRAC_BITS_DEF,
    parameter int VALUE_WIDTH = jac3_pkg::VALUE_WIDTH_DEF,
    parameter int COEF_WIDTH  = jac3_pkg::COEF_WIDTH_DEF
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     i_start,
    output logic                                    o_busy,
    input  wire logic signed [COEF_WIDTH-1:0]       i_eq1_x_coef, i_eq1_y_coef,
    input  wire logic signed [COEF_WIDTH-1:0]       i_eq1_z_coef, i_eq1_rhs,
    input  wire logic signed [COEF_WIDTH-1:0]       i_eq2_x_coef, i_eq2_y_coef,
    input  wire logic signed [COEF_WIDTH-1:0]       i_eq2_z_coef, i_eq2_rhs,
    input  wire logic signed [COEF_WIDTH-1:0]       i_eq3_x_coef, i_eq3_y_coef,
    input  wire logic signed [COEF_WIDTH-1:0]       i_eq3_z_coef, i_eq3_rhs,
    input  wire                                     i_cfg_we,
    input  wire logic [jac3_pkg::CFG_IDX_WIDTH-1:0] i_cfg_idx,
    input  wire logic [jac3_pkg::TOL_WIDTH-1:0]     i_cfg_data,
    output logic                                    o_valid,
    output logic [jac3_pkg::ITER_WIDTH-1:0]         o_iteration,
    output logic [VALUE_WIDTH-2:0]                  o_change_x, o_change_y, o_change_z,
    output logic signed [VALUE_WIDTH-1:0]           o_sol_x, o_sol_y, o_sol_z,
    output logic                                    o_found,
    output logic [jac3_pkg::ITER_WIDTH-1:0]         o_found_iteration,
    output logic                                    o_diag_zero,
    output logic                                    o_last
);
    import jac3_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_WAIT, S_DRAIN} t_state;

    t_state r_state;
    logic [TOL_WIDTH-1:0] r_tol_x, r_tol_yz;
    logic signed [COEF_WIDTH-1:0] r_a1, r_b1, r_c1, r_d1, r_a2, r_b2, r_c2, r_d2;
    logic signed [COEF_WIDTH-1:0] r_a3, r_b3, r_c3, r_d3;
    logic signed [VALUE_WIDTH-1:0] r_x, r_y, r_z;
    logic [ITER_WIDTH-1:0] r_iter;
    logic r_dz, r_clear, r_mvalid;
    t_lane_ctl ctl;
    logic [NUM_LANES-1:0] lane_done;
    logic signed [VALUE_WIDTH-1:0] nx, ny, nz;
    logic m_valid;
    logic accept;

    assign accept = i_start && !o_busy;
    assign ctl.start = (r_state == S_RUN);
    assign ctl.done = lane_done[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol_x <= TOL_X_RESET;
            r_tol_yz <= TOL_YZ_RESET;
        end else if (i_cfg_we && i_cfg_idx[CFG_IDX_WIDTH-1:1] == '0) begin
            unique case (i_cfg_idx[0])
                REG_TOL_X:  r_tol_x <= i_cfg_data;
                REG_TOL_YZ: r_tol_yz <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_clear <= 1'b0;
            r_mvalid <= 1'b0;
        end else begin
            r_clear <= 1'b0;
            r_mvalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_a1 <= i_eq1_x_coef; r_b1 <= i_eq1_y_coef;
                        r_c1 <= i_eq1_z_coef; r_d1 <= i_eq1_rhs;
                        r_a2 <= i_eq2_x_coef; r_b2 <= i_eq2_y_coef;
                        r_c2 <= i_eq2_z_coef; r_d2 <= i_eq2_rhs;
                        r_a3 <= i_eq3_x_coef; r_b3 <= i_eq3_y_coef;
                        r_c3 <= i_eq3_z_coef; r_d3 <= i_eq3_rhs;
                        r_dz <= (i_eq1_x_coef == '0) || (i_eq2_y_coef == '0)
                                || (i_eq3_z_coef == '0);
                        r_x <= '0; r_y <= '0; r_z <= '0;
                        r_iter <= ITER_WIDTH'(1);
                        r_clear <= 1'b1;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: r_state <= S_WAIT;
                S_WAIT: begin
                    if (ctl.done) begin
                        r_mvalid <= 1'b1;
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_x <= nx; r_y <= ny; r_z <= nz;
                    r_iter <= r_iter + 1'b1;
                    r_state <= (r_iter == ITER_WIDTH'(ITERATIONS)) ? S_IDLE : S_RUN;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign m_valid = r_mvalid;

    jac3_lane #(.FRAC_BITS(FRAC_BITS), .VALUE_WIDTH(VALUE_WIDTH), .COEF_WIDTH(COEF_WIDTH))
    u_lane_x (.i_clk, .i_rst_n, .i_start(ctl.start), .i_diag(r_a1), .i_c1(r_b1), .i_v1(r_y),
        .i_c2(r_c1), .i_v2(r_z), .i_rhs(r_d1), .o_done(lane_done[0]), .o_quot(nx));
    jac3_lane #(.FRAC_BITS(FRAC_BITS), .VALUE_WIDTH(VALUE_WIDTH), .COEF_WIDTH(COEF_WIDTH))
    u_lane_y (.i_clk, .i_rst_n, .i_start(ctl.start), .i_diag(r_b2), .i_c1(r_a2), .i_v1(r_x),
        .i_c2(r_c2), .i_v2(r_z), .i_rhs(r_d2), .o_done(lane_done[1]), .o_quot(ny));
    jac3_lane #(.FRAC_BITS(FRAC_BITS), .VALUE_WIDTH(VALUE_WIDTH), .COEF_WIDTH(COEF_WIDTH))
    u_lane_z (.i_clk, .i_rst_n, .i_start(ctl.start), .i_diag(r_c3), .i_c1(r_a3), .i_v1(r_x),
        .i_c2(r_b3), .i_v2(r_y), .i_rhs(r_d3), .o_done(lane_done[2]), .o_quot(nz));

    jac3_merge #(.ITERATIONS(ITERATIONS), .VALUE_WIDTH(VALUE_WIDTH)) u_merge (
        .i_clk, .i_rst_n, .i_clear(r_clear), .i_valid(m_valid), .i_iter(r_iter),
        .i_old_x(r_x), .i_old_y(r_y), .i_old_z(r_z),
        .i_new_x(nx), .i_new_y(ny), .i_new_z(nz),
        .i_tol_x(r_tol_x), .i_tol_yz(r_tol_yz),
        .o_valid, .o_iteration, .o_change_x, .o_change_y, .o_change_z,
        .o_sol_x, .o_sol_y, .o_sol_z, .o_found, .o_found_iteration, .o_last);

    assign o_diag_zero = r_dz;

`ifndef ASSERT_OFF
    a_lanes_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lane_done[0] |-> lane_done[1] && lane_done[2]) else $error("lanes out of step");
    a_iter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |-> r_iter != '0 && r_iter <= ITER_WIDTH'(ITERATIONS))
        else $error("iteration out of range");
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> !o_busy) else $error("busy after final transaction");
`endif
endmodule
`default_nettype wire

/* tb/tb_jacobi_3x3_solver_top.sv */
// Self-checking testbench for the 3x3 Jacobi solver: predicts each sweep result and compares
`timescale 1ns / 1ps
`default_nettype none
module tb_jacobi_3x3_solver_top;
    import jac3_pkg::*;

    localparam int NSWEEP = ITERATIONS_DEF;
    localparam int FRACB  = FRAC_BITS_DEF;
    localparam int VW     = VALUE_WIDTH_DEF;
    localparam longint unsigned VMAX = (64'd1 << (VW - 1)) - 1;
    localparam longint WHI = 64'sh7fff_ffff_ffff_ffff;
    localparam longint WLO = -WHI;
    localparam int N_RANDOM = 180;
    localparam longint CYCLE_LIMIT = 2_000_000;
    localparam logic [CFG_IDX_WIDTH-1:0] IDX_TOL_X  = CFG_IDX_WIDTH'(REG_TOL_X);
    localparam logic [CFG_IDX_WIDTH-1:0] IDX_TOL_YZ = CFG_IDX_WIDTH'(REG_TOL_YZ);
    localparam logic [CFG_IDX_WIDTH-1:0] IDX_UNUSED = CFG_IDX_WIDTH'(3);

    typedef struct {
        logic [ITER_WIDTH-1:0] iteration;
        logic [VW-2:0] change_x, change_y, change_z;
        logic signed [VW-1:0] sol_x, sol_y, sol_z;
        logic found;
        logic [ITER_WIDTH-1:0] found_iteration;
        logic diag_zero;
        logic last;
    } t_sweep;

    typedef logic signed [15:0] t_system [12];

    class sweep_scoreboard;
        t_sweep pending[$];
        logic [TOL_WIDTH-1:0] tol_x = TOL_X_RESET;
        logic [TOL_WIDTH-1:0] tol_yz = TOL_YZ_RESET;
        int mismatches = 0;
        int checked = 0;

        function longint sadd(longint a, longint b);
            if (b > 0 && a > WHI - b) return WHI;
            if (b < 0 && a < WLO - b) return WLO;
            return a + b;
        endfunction

        function longint smul(longint a, longint b);
            longint unsigned ma, mb;
            bit neg;
            ma = (a < 0) ? -a : a;
            mb = (b < 0) ? -b : b;
            neg = (a < 0) != (b < 0);
            if (ma != 0 && mb > longint'(WHI) / ma) return neg ? WLO : WHI;
            return neg ? -longint'(ma * mb) : longint'(ma * mb);
        endfunction

        function longint next_value(longint dg, longint c1, longint v1,
                                    longint c2, longint v2, longint rhs);
            longint n, q;
            n = smul(rhs, longint'(1) << FRACB);
            n = sadd(n, -smul(c1, v1));
            n = sadd(n, -smul(c2, v2));
            if (dg == 0) return (n > 0) ? longint'(VMAX) : (n < 0) ? -longint'(VMAX) - 1 : 0;
            q = n / dg;
            if (q > longint'(VMAX)) return VMAX;
            if (q < -longint'(VMAX) - 1) return -longint'(VMAX) - 1;
            return q;
        endfunction

        function longint unsigned delta(longint a, longint b);
            longint unsigned d;
            d = (a >= b) ? longint'(a - b) : longint'(b - a);
            return (d > VMAX) ? VMAX : d;
        endfunction

        function void write_tol(logic [CFG_IDX_WIDTH-1:0] idx, logic [TOL_WIDTH-1:0] v);
            if (idx == IDX_TOL_X) tol_x = v;
            else if (idx == IDX_TOL_YZ) tol_yz = v;
        endfunction

        function void note_system(t_system s);
            longint x, y, z, nx, ny, nz, rx, ry, rz;
            longint unsigned cx, cy, cz;
            bit hit;
            int hit_k;
            t_sweep r;
            x = 0; y = 0; z = 0; rx = 0; ry = 0; rz = 0; hit = 0; hit_k = 0;
            for (int k = 0; k < NSWEEP; k++) begin
                nx = next_value(s[0], s[1], y, s[2], z, s[3]);
                ny = next_value(s[5], s[4], x, s[6], z, s[7]);
                nz = next_value(s[10], s[8], x, s[9], y, s[11]);
                cx = delta(x, nx); cy = delta(y, ny); cz = delta(z, nz);
                if (!hit && cx <= tol_x && cy <= tol_yz && cz <= tol_yz) begin
                    hit = 1; hit_k = k + 1; rx = nx; ry = ny; rz = nz;
                end
                x = nx; y = ny; z = nz;
                r.iteration = ITER_WIDTH'(k + 1);
                r.change_x = (VW-1)'(cx); r.change_y = (VW-1)'(cy); r.change_z = (VW-1)'(cz);
                r.last = (k == NSWEEP - 1);
                r.sol_x = r.last ? VW'(rx) : '0;
                r.sol_y = r.last ? VW'(ry) : '0;
                r.sol_z = r.last ? VW'(rz) : '0;
                r.found = r.last && hit;
                r.found_iteration = r.last ? ITER_WIDTH'(hit_k) : '0;
                r.diag_zero = (s[0] == 0 || s[5] == 0 || s[10] == 0);
                pending = {pending, r};
            end
        endfunction

        task report(string what, longint got, longint want);
            mismatches++;
            if (mismatches <= 40)
                $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        endtask

        task check_sweep(t_sweep got);
            t_sweep e;
            checked++;
            if (pending.size() == 0) begin
                report("unexpected result", 0, 0);
                return;
            end
            e = pending.pop_front();
            if (got.iteration != e.iteration) report("iteration", got.iteration, e.iteration);
            if (got.change_x != e.change_x) report("change_x", got.change_x, e.change_x);
            if (got.change_y != e.change_y) report("change_y", got.change_y, e.change_y);
            if (got.change_z != e.change_z) report("change_z", got.change_z, e.change_z);
            if (got.sol_x != e.sol_x) report("sol_x", got.sol_x, e.sol_x);
            if (got.sol_y != e.sol_y) report("sol_y", got.sol_y, e.sol_y);
            if (got.sol_z != e.sol_z) report("sol_z", got.sol_z, e.sol_z);
            if (got.found != e.found) report("found", got.found, e.found);
            if (got.found_iteration != e.found_iteration)
                report("found_iteration", got.found_iteration, e.found_iteration);
            if (got.diag_zero != e.diag_zero) report("diag_zero", got.diag_zero, e.diag_zero);
            if (got.last != e.last) report("last", got.last, e.last);
        endtask
    endclass

    logic i_clk = 0, i_rst_n = 0, i_start = 0, o_busy;
    logic signed [15:0] eq [12];
    logic i_cfg_we = 0;
    logic [CFG_IDX_WIDTH-1:0] i_cfg_idx = '0;
    logic [TOL_WIDTH-1:0] i_cfg_data = '0;
    logic o_valid, o_found, o_diag_zero, o_last;
    logic [ITER_WIDTH-1:0] o_iteration, o_found_iteration;
    logic [VW-2:0] o_change_x, o_change_y, o_change_z;
    logic signed [VW-1:0] o_sol_x, o_sol_y, o_sol_z;
    sweep_scoreboard sb = new();
    longint cycles = 0;
    int systems = 0;

    initial foreach (eq[i]) eq[i] = '0;

    jacobi_3x3_solver_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_eq1_x_coef(eq[0]), .i_eq1_y_coef(eq[1]), .i_eq1_z_coef(eq[2]), .i_eq1_rhs(eq[3]),
        .i_eq2_x_coef(eq[4]), .i_eq2_y_coef(eq[5]), .i_eq2_z_coef(eq[6]), .i_eq2_rhs(eq[7]),
        .i_eq3_x_coef(eq[8]), .i_eq3_y_coef(eq[9]), .i_eq3_z_coef(eq[10]),
        .i_eq3_rhs(eq[11]),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .o_iteration(o_iteration),
        .o_change_x(o_change_x), .o_change_y(o_change_y), .o_change_z(o_change_z),
        .o_sol_x(o_sol_x), .o_sol_y(o_sol_y), .o_sol_z(o_sol_z),
        .o_found(o_found), .o_found_iteration(o_found_iteration),
        .o_diag_zero(o_diag_zero), .o_last(o_last)
    );

    initial forever #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        t_sweep got;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid) begin
            got.iteration = o_iteration;
            got.change_x = o_change_x; got.change_y = o_change_y; got.change_z = o_change_z;
            got.sol_x = o_sol_x; got.sol_y = o_sol_y; got.sol_z = o_sol_z;
            got.found = o_found; got.found_iteration = o_found_iteration;
            got.diag_zero = o_diag_zero; got.last = o_last;
            sb.check_sweep(got);
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 3);
        repeat (n) @(negedge i_clk);
    endtask

    // hold start until the block takes the transaction
    task automatic send_system(t_system s);
        @(negedge i_clk);
        foreach (eq[i]) eq[i] <= s[i];
        i_start <= 1;
        do @(posedge i_clk); while (o_busy);
        sb.note_system(s);
        systems++;
        @(negedge i_clk);
        i_start <= 0;
        foreach (eq[i]) eq[i] <= 16'($urandom);
        idle_gap();
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_tol(logic [CFG_IDX_WIDTH-1:0] idx, logic [TOL_WIDTH-1:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 0;
        sb.write_tol(idx, v);
    endtask

    function automatic t_system dominant_system();
        t_system s;
        foreach (s[i]) s[i] = $urandom_range(0, 3) == 0 ? 16'($urandom)
                                                        : 16'($signed($urandom_range(0, 40)) - 20);
        s[0] = 16'(($urandom_range(0, 1) ? 1 : -1) * $signed(16'($urandom_range(100, 32767))));
        s[5] = 16'(($urandom_range(0, 1) ? 1 : -1) * $signed(16'($urandom_range(100, 32767))));
        s[10] = 16'(($urandom_range(0, 1) ? 1 : -1) * $signed(16'($urandom_range(100, 32767))));
        if ($urandom_range(0, 30) == 0) s[$urandom_range(0, 2) * 5] = 0;
        return s;
    endfunction

    initial begin
        t_system s;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed: simple system, extremes, zero diagonals, all-zero input
        s = '{4, 1, 1, 6, 1, 4, 1, 6, 1, 1, 4, 6};
        send_system(s);
        foreach (s[i]) s[i] = 16'sh7fff;
        send_system(s);
        foreach (s[i]) s[i] = 16'sh8000;
        send_system(s);
        foreach (s[i]) s[i] = 0;
        send_system(s);
        s = '{0, 3, -2, 100, 2, 0, 1, -100, 1, 1, 0, 0};
        send_system(s);
        s = '{1, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 1, 16'sh7fff,
              16'sh8000, 16'sh7fff, 16'sh8000, -1, 16'sh7fff};
        send_system(s);
        s = '{-1, 0, 0, 16'sh8000, 0, 16'sh8000, 0, 16'sh8000, 0, 0, 16'sh7fff, 1};
        send_system(s);
        s = '{16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555,
              16'shaaaa, 16'sh5555, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa};
        send_system(s);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin write_tol(IDX_TOL_X, '0); write_tol(IDX_TOL_YZ, '0); end
                1: begin
                    write_tol(IDX_TOL_X, 25'h1000000); write_tol(IDX_TOL_YZ, 25'h1000000);
                end
                2: begin
                    write_tol(IDX_TOL_X, 25'h1ffffff); write_tol(IDX_TOL_YZ, 25'h1ffffff);
                    write_tol(IDX_UNUSED, 25'h0);
                end
                default: begin
                    write_tol(IDX_TOL_X, TOL_X_RESET); write_tol(IDX_TOL_YZ, TOL_YZ_RESET);
                end
            endcase
            for (int n = 0; n < N_RANDOM / 4; n++) begin
                if ($urandom_range(0, 4) == 0)
                    foreach (s[i]) s[i] = 16'($urandom);
                else
                    s = dominant_system();
                send_system(s);
            end
            drain();
        end

        $display("covered %0d systems, %0d sweep results, four tolerance settings",
                 systems, sb.checked);
        if (sb.mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
`default_nettype wire

/* filelist.f */
hdl/jac3_pkg.sv
hdl/jac3_lane.sv
hdl/jac3_merge.sv
hdl/jacobi_3x3_solver_top.sv
tb/tb_jacobi_3x3_solver_top.sv
